### rtl/core/sirslj_pkg.sv
package sirslj_pkg;

  // Width of internal row and column coordinates; holds any side up to 1024.
  localparam int CW = 11;

  // Width of the census totals and their saturation value.
  localparam int COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Width of the wall count and of the infection product terms.
  localparam int WALL_W = 9;
  localparam int DEN_W = 13;
  localparam int PROD_W = 16 + DEN_W;

  // Reciprocal of six for the seed position: x / 6 == (x * 43691) >> 18 for small x.
  localparam int SEED_MUL_W = 16;
  localparam logic [SEED_MUL_W-1:0] SEED_MUL = 16'd43691;
  localparam int SEED_SHIFT = 18;

  // Cell codes.
  localparam logic [1:0] CELL_WALL = 2'd0;
  localparam logic [1:0] CELL_SUS = 2'd1;
  localparam logic [1:0] CELL_INF = 2'd2;
  localparam logic [1:0] CELL_REC = 2'd3;

  // Action codes.
  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_JUMP = 2'd1;
  localparam logic [1:0] ACT_CENSUS = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_GRID_SIDE = 3'd0;
  localparam logic [2:0] REG_WALL_SPACING = 3'd1;
  localparam logic [2:0] REG_INFECT_BASE = 3'd2;
  localparam logic [2:0] REG_WALL_PENALTY = 3'd3;
  localparam logic [2:0] REG_RECOVER_PROB = 3'd4;
  localparam logic [2:0] REG_RELAPSE_PROB = 3'd5;

endpackage

### rtl/core/sirs_lattice_jump_event.sv
// Init beat: writes every cell of the MAX_SIDE x MAX_SIDE lattice, one lattice cell written per cycle.
// Census beat: reads the S*S cells of active side S, one cell read per cycle.
// Jump beat: the path walk reads one cell per cycle from the single lattice read port.
// Out-of-range and unused beats go straight to the result without touching the lattice.
// One beat is processed at a time; the result is held until taken.
// Reset loads the register defaults; the lattice reads as all walls until the first init.
module sirs_lattice_jump_event import sirslj_pkg::*; #(
  parameter int MAX_SIDE = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [15:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                action,
  input  logic [7:0]                src_row,
  input  logic [7:0]                src_col,
  input  logic signed [8:0]         jump_row,
  input  logic signed [8:0]         jump_col,
  input  logic [15:0]               draw_main,
  input  logic [15:0]               draw_relapse,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      status,
  output logic                      target_infected,
  output logic                      source_recovered,
  output logic                      source_relapsed,
  output logic [WALL_W-1:0]         walls_crossed,
  output logic [COUNT_W-1:0]        count_susceptible,
  output logic [COUNT_W-1:0]        count_infected,
  output logic [COUNT_W-1:0]        count_recovered
);

  localparam int AW = $clog2(MAX_SIDE);
  localparam int MW = 2 * AW;
  localparam int DEPTH = 1 << MW;
  localparam logic [CW-1:0] MAX_SIDE_C = CW'(MAX_SIDE);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SIDE - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_WALK_COL, S_WALK_ROW, S_RD_SRC, S_RD_TGT, S_WAIT,
    S_PROD, S_WR_TGT, S_WR_SRC, S_CENSUS, S_DRAIN, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    TAG_NONE, TAG_PATH, TAG_CENSUS, TAG_SRC, TAG_TGT
  } tag_t;

  // Configuration registers.
  logic [8:0]  grid_side;
  logic [8:0]  wall_spacing;
  logic [15:0] infect_base;
  logic [3:0]  wall_penalty;
  logic [15:0] recover_prob;
  logic [15:0] relapse_prob;

  state_t state;
  tag_t   issue_tag, rd_tag;
  logic   lat_valid;

  logic [CW-1:0] sr, sc, tr, tc, r, c, seed;
  logic          dn_r, dn_c;
  logic [15:0]   u, v;
  logic [DEN_W-1:0]  den;
  logic [PROD_W-1:0] prod;
  logic [1:0]    src_q, tgt_q;
  logic [AW-1:0] i, j;
  logic [8:0]    rmod, cmod;

  // Lattice memory.
  logic [1:0]    mem [DEPTH];
  logic [1:0]    mem_q;
  logic          mem_we;
  logic [MW-1:0] mem_waddr, mem_raddr;
  logic [1:0]    mem_wdata;
  logic [1:0]    rd_cell;

  // Effective side, spacing and derived values.
  logic [CW-1:0] s, s_m1, p;
  logic [SEED_SHIFT+CW-1:0] seed_prod;
  logic signed [CW:0] tr_full, tc_full;
  logic jump_ok;
  logic [1:0] init_cell;
  logic [CW-1:0] i_x, j_x;
  logic infect, recov, relapse;

  function automatic logic [MW-1:0] cell_addr(logic [CW-1:0] row, logic [CW-1:0] col);
    return {row[AW-1:0], col[AW-1:0]};
  endfunction

  always_comb begin
    priority if (CW'(grid_side) < CW'(3)) begin
      s = CW'(3);
    end else if (CW'(grid_side) > MAX_SIDE_C) begin
      s = MAX_SIDE_C;
    end else begin
      s = CW'(grid_side);
    end
  end

  assign s_m1 = s - CW'(1);
  assign p = (wall_spacing == '0) ? CW'(1) : CW'(wall_spacing);
  assign seed_prod = (SEED_SHIFT+CW)'(s + CW'(1)) * (SEED_SHIFT+CW)'(SEED_MUL);

  // Target position and range check of a jump beat.
  assign tr_full = $signed({{(CW+1-8){1'b0}}, src_row}) + (CW+1)'(jump_row);
  assign tc_full = $signed({{(CW+1-8){1'b0}}, src_col}) + (CW+1)'(jump_col);
  assign jump_ok = (CW'(src_row) < s) && (CW'(src_col) < s) &&
                   (tr_full >= $signed((CW+1)'(1))) &&
                   (tr_full <= $signed({1'b0, s_m1})) &&
                   (tc_full >= $signed((CW+1)'(1))) &&
                   (tc_full <= $signed({1'b0, s_m1}));

  // Initial pattern for the cell at the sweep position.
  assign i_x = CW'(i);
  assign j_x = CW'(j);
  always_comb begin
    if (i_x >= s || j_x >= s || rmod == '0 || cmod == '0 || i_x == s_m1 || j_x == s_m1) begin
      init_cell = CELL_WALL;
    end else if (i_x == seed && j_x == seed) begin
      init_cell = CELL_INF;
    end else begin
      init_cell = CELL_SUS;
    end
  end

  // Event decisions once both cells and the product are known.
  assign infect = (src_q == CELL_INF) && (prod < PROD_W'(infect_base)) && (tgt_q == CELL_SUS);
  assign recov = (src_q == CELL_INF) && (u < recover_prob);
  assign relapse = (recov || src_q == CELL_REC) && (v < relapse_prob);

  // Memory port addressing per state.
  always_comb begin
    mem_raddr = '0;
    issue_tag = TAG_NONE;
    unique case (state)
      S_WALK_COL: begin
        mem_raddr = cell_addr(r, sc);
        issue_tag = (r != tr) ? TAG_PATH : TAG_NONE;
      end
      S_WALK_ROW: begin
        mem_raddr = cell_addr(tr, c);
        issue_tag = (c != tc) ? TAG_PATH : TAG_NONE;
      end
      S_RD_SRC: begin
        mem_raddr = cell_addr(sr, sc);
        issue_tag = TAG_SRC;
      end
      S_RD_TGT: begin
        mem_raddr = cell_addr(tr, tc);
        issue_tag = TAG_TGT;
      end
      S_CENSUS: begin
        mem_raddr = cell_addr(i_x, j_x);
        issue_tag = TAG_CENSUS;
      end
      default: begin
        mem_raddr = '0;
        issue_tag = TAG_NONE;
      end
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cell_addr(sr, sc);
    mem_wdata = source_relapsed ? CELL_SUS : CELL_REC;
    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        mem_waddr = cell_addr(i_x, j_x);
        mem_wdata = init_cell;
      end
      S_WR_TGT: begin
        mem_we = infect;
        mem_waddr = cell_addr(tr, tc);
        mem_wdata = CELL_INF;
      end
      S_WR_SRC: begin
        mem_we = source_recovered || source_relapsed;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  // Cells read before the first init are walls.
  assign rd_cell = lat_valid ? mem_q : CELL_WALL;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= 9'd200;
      wall_spacing <= 9'd40;
      infect_base <= 16'd52429;
      wall_penalty <= 4'd4;
      recover_prob <= 16'd9830;
      relapse_prob <= 16'd1311;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_SIDE:    grid_side <= cfg_data[8:0];
        REG_WALL_SPACING: wall_spacing <= cfg_data[8:0];
        REG_INFECT_BASE:  infect_base <= cfg_data;
        REG_WALL_PENALTY: wall_penalty <= cfg_data[3:0];
        REG_RECOVER_PROB: recover_prob <= cfg_data;
        REG_RELAPSE_PROB: relapse_prob <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // Sequencer, read capture and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rd_tag <= TAG_NONE;
      lat_valid <= 1'b0;
    end else begin
      rd_tag <= issue_tag;

      // Read data returns in the cycle after issue.
      unique case (rd_tag)
        TAG_PATH: begin
          if (rd_cell == CELL_WALL) begin
            walls_crossed <= walls_crossed + WALL_W'(1);
          end
        end
        TAG_CENSUS: begin
          unique case (rd_cell)
            CELL_SUS: if (count_susceptible != COUNT_MAX) begin
              count_susceptible <= count_susceptible + COUNT_W'(1);
            end
            CELL_INF: if (count_infected != COUNT_MAX) begin
              count_infected <= count_infected + COUNT_W'(1);
            end
            CELL_REC: if (count_recovered != COUNT_MAX) begin
              count_recovered <= count_recovered + COUNT_W'(1);
            end
            default: ;
          endcase
        end
        TAG_SRC: src_q <= rd_cell;
        TAG_TGT: tgt_q <= rd_cell;
        default: ;
      endcase

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            status <= 1'b0;
            target_infected <= 1'b0;
            source_recovered <= 1'b0;
            source_relapsed <= 1'b0;
            walls_crossed <= '0;
            count_susceptible <= '0;
            count_infected <= '0;
            count_recovered <= '0;
            i <= '0;
            j <= '0;
            rmod <= '0;
            cmod <= '0;
            seed <= seed_prod[SEED_SHIFT +: CW];
            sr <= CW'(src_row);
            sc <= CW'(src_col);
            r <= CW'(src_row);
            c <= CW'(src_col);
            tr <= tr_full[CW-1:0];
            tc <= tc_full[CW-1:0];
            dn_r <= tr_full < $signed({{(CW+1-8){1'b0}}, src_row});
            dn_c <= tc_full < $signed({{(CW+1-8){1'b0}}, src_col});
            u <= draw_main;
            v <= draw_relapse;
            unique case (action)
              ACT_INIT: state <= S_INIT;
              ACT_JUMP: begin
                if (jump_ok) begin
                  state <= S_WALK_COL;
                end else begin
                  status <= 1'b1;
                  state <= S_OUT;
                end
              end
              ACT_CENSUS: state <= S_CENSUS;
              default: state <= S_OUT;
            endcase
          end
        end
        S_INIT: begin
          if (j == LAST_IDX) begin
            j <= '0;
            cmod <= '0;
            i <= i + AW'(1);
            rmod <= (CW'(rmod) + CW'(1) == p) ? '0 : rmod + 9'd1;
            if (i == LAST_IDX) begin
              lat_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            j <= j + AW'(1);
            cmod <= (CW'(cmod) + CW'(1) == p) ? '0 : cmod + 9'd1;
          end
        end
        S_WALK_COL: begin
          if (r != tr) begin
            r <= dn_r ? r - CW'(1) : r + CW'(1);
          end else begin
            state <= S_WALK_ROW;
          end
        end
        S_WALK_ROW: begin
          if (c != tc) begin
            c <= dn_c ? c - CW'(1) : c + CW'(1);
          end else begin
            state <= S_RD_SRC;
          end
        end
        S_RD_SRC: state <= S_RD_TGT;
        S_RD_TGT: state <= S_WAIT;
        S_WAIT: begin
          // The last path cell has already been counted, so walls_crossed is final.
          den <= {{(DEN_W-4){1'b0}}, wall_penalty} * {{(DEN_W-WALL_W){1'b0}}, walls_crossed}
                 + DEN_W'(1);
          state <= S_PROD;
        end
        S_PROD: begin
          prod <= PROD_W'(u) * PROD_W'(den);
          state <= S_WR_TGT;
        end
        S_WR_TGT: begin
          target_infected <= infect;
          source_recovered <= recov;
          source_relapsed <= relapse;
          state <= S_WR_SRC;
        end
        S_WR_SRC: state <= S_OUT;
        S_CENSUS: begin
          if (CW'(j) == s_m1) begin
            j <= '0;
            if (CW'(i) == s_m1) begin
              state <= S_DRAIN;
            end else begin
              i <= i + AW'(1);
            end
          end else begin
            j <= j + AW'(1);
          end
        end
        S_DRAIN: state <= S_OUT;
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The input side is closed while a result waits.
  a_busy_out: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  // An out-of-range jump changes nothing and counts no walls.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (walls_crossed == '0 && !target_infected &&
                               !source_recovered && !source_relapsed))
    else $error("error result carries event flags");

  // The lattice is written only by the init sweep or the write-back states.
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_INIT || state == S_WR_TGT || state == S_WR_SRC))
    else $error("lattice write outside write states");

  // Event results carry no census totals.
  a_census_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (target_infected || source_recovered || source_relapsed)) |->
      (count_susceptible == '0 && count_infected == '0 && count_recovered == '0))
    else $error("census totals on an event result");

endmodule
